/* hdl/lfp_pkg.sv */
// Shared types and constants for the rangefinder frame parser.
// Used by every module under hdl/; depends on nothing else.

package lfp_pkg;

	localparam int ByteW = 8;
	localparam int WordW = 16;
	localparam int TempW = 17;
	localparam int PosW = 4;
	localparam int CfgIdxW = 2;

	localparam logic [ByteW-1:0] HEADER_BYTE = 8'h59;
	localparam logic [WordW-1:0] AMP_SATURATED = 16'hFFFF;
	localparam logic [TempW-1:0] TEMP_OFFSET = 17'd2048;

	// Byte positions within a frame, counted as bytes taken so far.
	localparam logic [PosW-1:0] POS_HUNT = 4'd0;
	localparam logic [PosW-1:0] POS_HDR2 = 4'd1;
	localparam logic [PosW-1:0] POS_DIST_LO = 4'd2;
	localparam logic [PosW-1:0] POS_DIST_HI = 4'd3;
	localparam logic [PosW-1:0] POS_AMP_LO = 4'd4;
	localparam logic [PosW-1:0] POS_AMP_HI = 4'd5;
	localparam logic [PosW-1:0] POS_TEMP_LO = 4'd6;
	localparam logic [PosW-1:0] POS_TEMP_HI = 4'd7;
	localparam logic [PosW-1:0] POS_CSUM = 4'd8;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_MIN_AMP = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_MIN_DIST = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MAX_DIST = 2'd2;

	localparam logic [WordW-1:0] MIN_AMP_RESET = 16'd100;
	localparam logic [WordW-1:0] MIN_DIST_RESET = 16'd10;
	localparam logic [WordW-1:0] MAX_DIST_RESET = 16'd800;

	typedef struct packed {
		logic [WordW-1:0] dist_cm;
		logic [WordW-1:0] amp;
		logic [WordW-1:0] traw;
	} lfp_frame_t;

	typedef struct packed {
		logic [WordW-1:0] min_amp;
		logic [WordW-1:0] min_dist;
		logic [WordW-1:0] max_dist;
	} lfp_limits_t;

endpackage

/* hdl/lidar_frame_parser.sv */
// Top level of the rangefinder frame parser: configuration registers, byte
// collector and result stage. Depends on lfp_pkg, lfp_cfg_regs, lfp_collect, lfp_check.
//
// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_stall   data_byte
// out      source     out_valid / out_stall distance_cm, reading_valid, temperature_eighths
// cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low. A good frame passes, after
// the transfer of its checksum byte, through the frame register and then the
// result register to the output. Reset clears the byte position and both valid
// flags and loads the default limits. The input stalls only while a finished
// frame and an earlier result are both held and the output is stalled.

module lidar_frame_parser
	import lfp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [ByteW-1:0]        data_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [WordW-1:0]        distance_cm,
	output logic                    reading_valid,
	output logic signed [TempW-1:0] temperature_eighths,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CfgIdxW-1:0]      cfg_index,
	input  logic [WordW-1:0]        cfg_data
);

	lfp_limits_t limits;
	lfp_frame_t  frame_s1;
	logic        frame_valid_s1;
	logic        frame_take;
	logic        byte_take;

	assign in_stall = frame_valid_s1 && !frame_take;
	assign byte_take = in_valid && !in_stall;

	lfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	lfp_collect u_collect (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_take      (byte_take),
		.data_byte      (data_byte),
		.frame_take     (frame_take),
		.frame_valid_s1 (frame_valid_s1),
		.frame_s1       (frame_s1)
	);

	lfp_check u_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.frame_valid_s1      (frame_valid_s1),
		.frame_s1            (frame_s1),
		.limits              (limits),
		.frame_take          (frame_take),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.distance_cm         (distance_cm),
		.reading_valid       (reading_valid),
		.temperature_eighths (temperature_eighths)
	);

endmodule

/* hdl/lfp_cfg_regs.sv */
// Configuration registers for the frame parser: amplitude and distance limits.
// Depends on lfp_pkg.

module lfp_cfg_regs
	import lfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [WordW-1:0]   cfg_data,
	output lfp_limits_t        limits
);

	lfp_limits_t limits_q;

	assign cfg_ready = 1'b1;
	assign limits = limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.min_amp <= MIN_AMP_RESET;
			limits_q.min_dist <= MIN_DIST_RESET;
			limits_q.max_dist <= MAX_DIST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			// An index past the last register is ignored.
			unique case (cfg_index)
				CFG_MIN_AMP: limits_q.min_amp <= cfg_data;
				CFG_MIN_DIST: limits_q.min_dist <= cfg_data;
				CFG_MAX_DIST: limits_q.max_dist <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

/* hdl/lfp_collect.sv */
// Byte collector: header hunt, byte position counter, running checksum and
// frame field capture. Depends on lfp_pkg.

module lfp_collect
	import lfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_take,
	input  logic [ByteW-1:0] data_byte,
	input  logic             frame_take,
	output logic             frame_valid_s1,
	output lfp_frame_t       frame_s1
);

	logic [PosW-1:0]  pos_q;
	logic [PosW-1:0]  pos_next;
	logic [ByteW-1:0] sum_q;
	logic [ByteW-1:0] sum_next;
	logic [ByteW-1:0] dist_lo_q;
	logic [ByteW-1:0] dist_hi_q;
	logic [ByteW-1:0] amp_lo_q;
	logic [ByteW-1:0] amp_hi_q;
	logic [ByteW-1:0] temp_lo_q;
	logic [ByteW-1:0] temp_hi_q;
	logic             frame_done;

	// The running sum covers bytes 0 to 7, so the checksum byte is simply
	// compared against it when it arrives.
	always_comb begin
		pos_next = POS_HUNT;
		sum_next = sum_q;
		frame_done = 1'b0;
		case (pos_q) inside
			POS_HDR2: begin
				if (data_byte == HEADER_BYTE) begin
					pos_next = POS_DIST_LO;
					sum_next = sum_q + data_byte;
				end
			end
			[POS_DIST_LO:POS_TEMP_HI]: begin
				pos_next = pos_q + 4'd1;
				sum_next = sum_q + data_byte;
			end
			POS_CSUM: begin
				frame_done = (sum_q == data_byte);
			end
			default: begin
				// Hunting, including positions that cannot normally occur.
				if (data_byte == HEADER_BYTE) begin
					pos_next = POS_HDR2;
					sum_next = data_byte;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			frame_valid_s1 <= 1'b0;
		end else begin
			if (byte_take) begin
				pos_q <= pos_next;
			end
			if (byte_take && frame_done) begin
				frame_valid_s1 <= 1'b1;
			end else if (frame_take) begin
				frame_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_take) begin
			sum_q <= sum_next;
			case (pos_q)
				POS_DIST_LO: dist_lo_q <= data_byte;
				POS_DIST_HI: dist_hi_q <= data_byte;
				POS_AMP_LO: amp_lo_q <= data_byte;
				POS_AMP_HI: amp_hi_q <= data_byte;
				POS_TEMP_LO: temp_lo_q <= data_byte;
				POS_TEMP_HI: temp_hi_q <= data_byte;
				default: ;
			endcase
			if (frame_done) begin
				frame_s1.dist_cm <= {dist_hi_q, dist_lo_q};
				frame_s1.amp <= {amp_hi_q, amp_lo_q};
				frame_s1.traw <= {temp_hi_q, temp_lo_q};
			end
		end
	end

endmodule

/* hdl/lfp_check.sv */
// Limit checks, temperature offset and the result register with its
// handshake. Depends on lfp_pkg.

module lfp_check
	import lfp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    frame_valid_s1,
	input  lfp_frame_t              frame_s1,
	input  lfp_limits_t             limits,
	output logic                    frame_take,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [WordW-1:0]        distance_cm,
	output logic                    reading_valid,
	output logic signed [TempW-1:0] temperature_eighths
);

	logic                    out_valid_q;
	logic [WordW-1:0]        dist_q;
	logic                    ok_q;
	logic signed [TempW-1:0] temp_q;
	logic                    ok;
	logic [TempW-1:0]        temp;

	assign ok = (frame_s1.amp >= limits.min_amp) && (frame_s1.amp != AMP_SATURATED) &&
		(frame_s1.dist_cm >= limits.min_dist) && (frame_s1.dist_cm <= limits.max_dist);
	assign temp = {1'b0, frame_s1.traw} - TEMP_OFFSET;

	// The frame moves on whenever the result register is empty or being read.
	assign frame_take = frame_valid_s1 && !(out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			dist_q <= frame_s1.dist_cm;
			ok_q <= ok;
			temp_q <= signed'(temp);
		end
	end

	assign out_valid = out_valid_q;
	assign distance_cm = dist_q;
	assign reading_valid = ok_q;
	assign temperature_eighths = temp_q;

endmodule
